// ----- rtl/rhr_pkg.sv -----
// shared types and constants for the root hub request handler
// request codes, feature selectors, port word bit masks and the reply plan type
// no dependencies
package rhr_pkg;

  localparam int unsigned ReplyDepth = 9;
  localparam int unsigned IdxW       = $clog2(ReplyDepth);

  // standard request codes
  localparam logic [7:0] RqGetStatus     = 8'd0;
  localparam logic [7:0] RqClearFeature  = 8'd1;
  localparam logic [7:0] RqGetState      = 8'd2;
  localparam logic [7:0] RqSetFeature    = 8'd3;
  localparam logic [7:0] RqSetAddress    = 8'd5;
  localparam logic [7:0] RqGetDescriptor = 8'd6;
  localparam logic [7:0] RqSetDescriptor = 8'd7;
  localparam logic [7:0] RqGetConfig     = 8'd8;
  localparam logic [7:0] RqSetConfig     = 8'd9;
  localparam logic [7:0] RqGetInterface  = 8'd10;
  localparam logic [7:0] RqSetInterface  = 8'd11;
  localparam logic [7:0] RqSynchFrame    = 8'd12;

  // request types
  localparam logic [7:0] TypeDevOut  = 8'h00;
  localparam logic [7:0] TypeIfOut   = 8'h01;
  localparam logic [7:0] TypeEpOut   = 8'h02;
  localparam logic [7:0] TypeHubOut  = 8'h20;
  localparam logic [7:0] TypeDevIn   = 8'h80;
  localparam logic [7:0] TypeIfIn    = 8'h81;
  localparam logic [7:0] TypeEpIn    = 8'h82;
  localparam logic [7:0] TypePortOut = 8'h23;
  localparam logic [7:0] TypePortIn  = 8'hA3;
  localparam logic [7:0] TypeHubIn   = 8'hA0;

  // port feature selectors
  localparam logic [15:0] FsPortEnable  = 16'd1;
  localparam logic [15:0] FsPortSuspend = 16'd2;
  localparam logic [15:0] FsPortReset   = 16'd4;
  localparam logic [15:0] FsPortPower   = 16'd8;
  localparam logic [15:0] FsCPortConn   = 16'd16;
  localparam logic [15:0] FsCPortEnable = 16'd17;

  // port status/control word bits
  localparam logic [31:0] WcMask   = 32'hFFFF_FFF5;
  localparam logic [31:0] BitCsc   = 32'h0000_0002;
  localparam logic [31:0] BitPed   = 32'h0000_0004;
  localparam logic [31:0] BitPedc  = 32'h0000_0008;
  localparam logic [31:0] BitSusp  = 32'h0000_0080;
  localparam logic [31:0] BitPr    = 32'h0000_0100;
  localparam logic [31:0] BitLs    = 32'h0000_0C00;
  localparam logic [31:0] LsLow    = 32'h0000_0400;
  localparam logic [31:0] BitPo    = 32'h0000_2000;

  // hub descriptor constants
  localparam logic [7:0] DescLen       = 8'd9;
  localparam logic [7:0] DescTypeHub   = 8'h29;
  localparam logic [7:0] DescChar      = 8'h09;
  localparam logic [7:0] DescPwrOnGood = 8'd1;
  localparam logic [7:0] DescCurrent   = 8'd100;
  localparam logic [7:0] DescPwrMask   = 8'hFF;
  localparam logic [7:0] StatHiword    = 8'h05;

  // everything needed to emit the results of one request
  typedef struct packed {
    logic                            err;
    logic                            we;
    logic [31:0]                     word;
    logic                            rv;
    logic [ReplyDepth-1:0][7:0]      bytes;
    logic [IdxW-1:0]                 last_idx;
  } plan_t;

endpackage

// ----- rtl/usb_root_hub_request_handler.sv -----
// top level of the root hub request handler: request register, port count
// register, decode and result sequencer; uses rhr_pkg, rhr_decode, rhr_emitter
//
// Usage
//   The request channel (in_valid_i / in_stall_o) carries one control request
//   with the current word of the addressed root port. The result channel
//   (out_valid_o / out_stall_i) carries the result items of that request in
//   order; reply_last_o marks the final one. A request gives one item, except
//   get-port-status (four reply bytes) and get-hub-descriptor (nine).
//   The first result of a request passes the request register and then the
//   plan register before it is shown. The result sequencer emits one item per
//   cycle while the receiver does not stall; under that condition single-item
//   requests also run at one per cycle. The request register takes the next
//   request while a plan is still being emitted.
//   The user must write port_count through cfg_we_i / cfg_wdata_i only while
//   idle; the block does not enforce this. It is limited to MAX_PORTS. Reset
//   empties both stages and sets port_count to 15. While the receiver stalls,
//   the shown item holds; the request register fills, then stalls the sender.
module usb_root_hub_request_handler #(
  parameter int unsigned MAX_PORTS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] feature_value_i,
  input  logic [7:0]  port_number_i,
  input  logic [31:0] port_word_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        error_flag_o,
  output logic        port_write_enable_o,
  output logic [31:0] port_word_out_o,
  output logic        reply_valid_o,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o
);

  localparam logic [3:0] MaxPortsW = 4'(MAX_PORTS);

  logic [3:0]     port_count_q;
  logic [3:0]     eff_count;
  logic           req_valid_q;
  logic [7:0]     req_type_q, req_code_q, req_port_q;
  logic [15:0]    req_feat_q;
  logic [31:0]    req_word_q;
  rhr_pkg::plan_t plan;
  logic           emit_free, plan_load, in_xfer;

  assign eff_count  = (port_count_q > MaxPortsW) ? MaxPortsW : port_count_q;
  assign plan_load  = req_valid_q && emit_free;
  assign in_stall_o = req_valid_q && !emit_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_count_q <= 4'd15;
      req_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        port_count_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        req_valid_q <= 1'b1;
      end else if (plan_load) begin
        req_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_type_q <= request_type_i;
      req_code_q <= request_code_i;
      req_feat_q <= feature_value_i;
      req_port_q <= port_number_i;
      req_word_q <= port_word_in_i;
    end
  end

  rhr_decode u_decode (
    .request_type_i  (req_type_q),
    .request_code_i  (req_code_q),
    .feature_value_i (req_feat_q),
    .port_number_i   (req_port_q),
    .port_word_in_i  (req_word_q),
    .eff_count_i     (eff_count),
    .plan_o          (plan)
  );

  rhr_emitter u_emitter (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .load_i              (plan_load),
    .plan_i              (plan),
    .free_o              (emit_free),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .error_flag_o        (error_flag_o),
    .port_write_enable_o (port_write_enable_o),
    .port_word_out_o     (port_word_out_o),
    .reply_valid_o       (reply_valid_o),
    .reply_byte_o        (reply_byte_o),
    .reply_last_o        (reply_last_o)
  );

endmodule

// ----- rtl/rhr_decode.sv -----
// request decode: turns one registered request into a reply plan
// purely combinational; uses rhr_pkg
module rhr_decode (
  input  logic [7:0]     request_type_i,
  input  logic [7:0]     request_code_i,
  input  logic [15:0]    feature_value_i,
  input  logic [7:0]     port_number_i,
  input  logic [31:0]    port_word_in_i,
  input  logic [3:0]     eff_count_i,
  output rhr_pkg::plan_t plan_o
);

  logic        noop;
  logic        port_clear, port_set, port_stat, get_desc;
  logic        bad_port;
  logic [31:0] masked;
  logic        wr;
  logic [31:0] nw;

  always_comb begin
    noop = 1'b0;
    case (request_code_i)
      rhr_pkg::RqClearFeature, rhr_pkg::RqSetFeature: begin
        noop = request_type_i inside {rhr_pkg::TypeDevOut, rhr_pkg::TypeIfOut,
                                      rhr_pkg::TypeEpOut, rhr_pkg::TypeHubOut};
      end
      rhr_pkg::RqGetStatus: begin
        noop = request_type_i inside {rhr_pkg::TypeDevIn, rhr_pkg::TypeIfIn,
                                      rhr_pkg::TypeEpIn, rhr_pkg::TypeHubIn};
      end
      rhr_pkg::RqGetConfig, rhr_pkg::RqGetDescriptor: begin
        noop = (request_type_i == rhr_pkg::TypeDevIn);
      end
      rhr_pkg::RqGetInterface: begin
        noop = (request_type_i == rhr_pkg::TypeIfIn);
      end
      rhr_pkg::RqSetAddress, rhr_pkg::RqSetConfig: begin
        noop = (request_type_i == rhr_pkg::TypeDevOut);
      end
      rhr_pkg::RqSetDescriptor: begin
        noop = request_type_i inside {rhr_pkg::TypeDevOut, rhr_pkg::TypeHubOut};
      end
      rhr_pkg::RqSetInterface: begin
        noop = (request_type_i == rhr_pkg::TypeIfOut);
      end
      rhr_pkg::RqSynchFrame: begin
        noop = (request_type_i == rhr_pkg::TypeEpIn);
      end
      rhr_pkg::RqGetState: begin
        noop = (request_type_i == rhr_pkg::TypePortIn);
      end
      default: noop = 1'b0;
    endcase
  end

  assign get_desc   = (request_type_i == rhr_pkg::TypeHubIn) &&
                      (request_code_i == rhr_pkg::RqGetDescriptor);
  assign port_clear = (request_type_i == rhr_pkg::TypePortOut) &&
                      (request_code_i == rhr_pkg::RqClearFeature);
  assign port_set   = (request_type_i == rhr_pkg::TypePortOut) &&
                      (request_code_i == rhr_pkg::RqSetFeature);
  assign port_stat  = (request_type_i == rhr_pkg::TypePortIn) &&
                      (request_code_i == rhr_pkg::RqGetStatus);
  assign bad_port   = (port_number_i == 8'd0) || (port_number_i > {4'd0, eff_count_i});
  assign masked     = port_word_in_i & rhr_pkg::WcMask;

  // port feature write
  always_comb begin
    wr = 1'b1;
    nw = '0;
    if (port_clear) begin
      case (feature_value_i)
        rhr_pkg::FsPortEnable:  nw = masked & ~rhr_pkg::BitPed;
        rhr_pkg::FsPortSuspend: nw = masked & ~rhr_pkg::BitSusp;
        rhr_pkg::FsCPortConn:   nw = masked | rhr_pkg::BitCsc;
        rhr_pkg::FsCPortEnable: nw = masked | rhr_pkg::BitPedc;
        default:                wr = 1'b0;
      endcase
    end else begin
      case (feature_value_i)
        rhr_pkg::FsPortReset: begin
          // low-speed device: hand the port to the companion controller
          if ((port_word_in_i & rhr_pkg::BitLs) != rhr_pkg::LsLow) begin
            nw = masked | rhr_pkg::BitPr;
          end else begin
            nw = masked | rhr_pkg::BitPo;
          end
        end
        rhr_pkg::FsPortSuspend: nw = masked | rhr_pkg::BitSusp;
        rhr_pkg::FsPortPower:   nw = masked;
        default:                wr = 1'b0;
      endcase
    end
  end

  always_comb begin
    plan_o = '0;
    if (get_desc) begin
      plan_o.rv       = 1'b1;
      plan_o.bytes[0] = rhr_pkg::DescLen;
      plan_o.bytes[1] = rhr_pkg::DescTypeHub;
      plan_o.bytes[2] = {4'd0, eff_count_i};
      plan_o.bytes[3] = rhr_pkg::DescChar;
      plan_o.bytes[4] = 8'h00;
      plan_o.bytes[5] = rhr_pkg::DescPwrOnGood;
      plan_o.bytes[6] = rhr_pkg::DescCurrent;
      plan_o.bytes[7] = 8'h00;
      plan_o.bytes[8] = rhr_pkg::DescPwrMask;
      plan_o.last_idx = rhr_pkg::IdxW'(rhr_pkg::ReplyDepth - 1);
    end else if (noop) begin
      plan_o.last_idx = '0;
    end else if (!(port_clear || port_set || port_stat) || bad_port) begin
      plan_o.err = 1'b1;
    end else if (port_stat) begin
      plan_o.rv       = 1'b1;
      plan_o.bytes[0] = {3'd0, port_word_in_i[8], 1'b0, port_word_in_i[7],
                         port_word_in_i[2], port_word_in_i[0]};
      plan_o.bytes[1] = rhr_pkg::StatHiword;
      plan_o.bytes[2] = {6'd0, port_word_in_i[3], port_word_in_i[1]};
      plan_o.bytes[3] = 8'h00;
      plan_o.last_idx = rhr_pkg::IdxW'(3);
    end else begin
      plan_o.we   = wr;
      plan_o.word = wr ? nw : '0;
    end
  end

endmodule

// ----- rtl/rhr_emitter.sv -----
// result sequencer: holds one reply plan and emits its items one per cycle while not stalled
// uses rhr_pkg
module rhr_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  rhr_pkg::plan_t plan_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           error_flag_o,
  output logic           port_write_enable_o,
  output logic [31:0]    port_word_out_o,
  output logic           reply_valid_o,
  output logic [7:0]     reply_byte_o,
  output logic           reply_last_o
);

  logic                     valid_q;
  rhr_pkg::plan_t           plan_q;
  logic [rhr_pkg::IdxW-1:0] idx_q;
  logic                     xfer, last;

  assign last   = (idx_q == plan_q.last_idx);
  assign xfer   = valid_q && !out_stall_i;
  assign free_o = !valid_q || (xfer && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (xfer) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + rhr_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plan_q <= plan_i;
    end
  end

  assign out_valid_o         = valid_q;
  assign error_flag_o        = plan_q.err;
  assign port_write_enable_o = plan_q.we;
  assign port_word_out_o     = plan_q.word;
  assign reply_valid_o       = plan_q.rv;
  assign reply_byte_o        = plan_q.bytes[idx_q];
  assign reply_last_o        = last;

endmodule

// ----- rtl/rhr_checker.sv -----
// port-level checks for the root hub request handler, bound to the top level
// sees only the top-level ports; no package dependency
module rhr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        error_flag_o,
  input logic        port_write_enable_o,
  input logic [31:0] port_word_out_o,
  input logic        reply_valid_o,
  input logic        reply_last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an error item stands alone: final, no data, no write
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> reply_last_o && !reply_valid_o && !port_write_enable_o)
    else $error("error item is not a lone final item");

  // a port write is a single final item without reply data
  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && port_write_enable_o |-> reply_last_o && !reply_valid_o)
    else $error("port write is not a lone final item");

  // reply bytes of one request follow each other with no gap
  a_reply_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && reply_valid_o && !reply_last_o
      |=> out_valid_o && reply_valid_o)
    else $error("gap inside a reply burst");

  // the port word is zero unless it is written
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !port_write_enable_o |-> port_word_out_o == 32'd0)
    else $error("port word set without a write");

endmodule

bind usb_root_hub_request_handler rhr_checker u_rhr_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .error_flag_o        (error_flag_o),
  .port_write_enable_o (port_write_enable_o),
  .port_word_out_o     (port_word_out_o),
  .reply_valid_o       (reply_valid_o),
  .reply_last_o        (reply_last_o)
);
